/* rtl/rsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

    // CORDIC step count
    localparam int ATAN_ITERATIONS = 16;
    localparam int ITER_W          = 5;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ATAN_ITERATIONS - 1);

    localparam logic [14:0] CENTER_ANGLE = 15'd11520;
    localparam logic [14:0] PIVOT_LOW    = 15'd4608;
    localparam logic [14:0] PIVOT_HIGH   = 15'd18432;
    localparam logic [15:0] ONE_Q14      = 16'd16384;

    // register indexes
    localparam logic [2:0] REG_MIN_RADIUS  = 3'd0;
    localparam logic [2:0] REG_HALF_WBASE  = 3'd1;
    localparam logic [2:0] REG_HALF_TRACK  = 3'd2;
    localparam logic [2:0] REG_STEER_DB    = 3'd3;
    localparam logic [2:0] REG_DRIVE_DB    = 3'd4;
    localparam logic [2:0] REG_INVERT_MASK = 3'd5;

    typedef enum logic [1:0] {
        CMD_TRACTION  = 2'd0,
        CMD_ACKERMANN = 2'd1,
        CMD_CRAB      = 2'd2,
        CMD_PIVOT     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [15:0] min_radius;
        logic [15:0] half_wbase;
        logic [15:0] half_track;
        logic [14:0] steer_db;
        logic [14:0] drive_db;
        logic [3:0]  invert_mask;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic              latch;
        logic              exec;
        logic              mul_w;
        logic              setup;
        logic              norm;
        logic              iter;
        logic              store;
        logic              outer;
        logic              load_out;
        logic [ITER_W-1:0] iter_idx;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic ack_work;
        logic special;
        logic norm_done;
    } t_dp_status;

    // atan(2^-i) in degrees, Q16
    function automatic logic [21:0] atan_q16(input logic [ITER_W-1:0] idx);
        logic [21:0] r;
        case (idx)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/rsd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsd_ctrl
    import rsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  wire logic       i_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MULW, S_SETUP, S_NORM, S_ITER, S_STORE, S_FINISH
    } t_state;

    t_state            r_state;
    logic [ITER_W-1:0] r_iter;
    logic              r_outer;
    logic              r_o_valid;
    logic              out_free;

    assign out_free = !r_o_valid || !i_stall;
    // no word is taken while in reset
    assign o_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_valid  = r_o_valid;

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.latch    = (r_state == S_IDLE) && i_valid;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.mul_w    = (r_state == S_MULW);
        o_cmd.setup    = (r_state == S_SETUP);
        o_cmd.norm     = (r_state == S_NORM) && !i_status.norm_done;
        o_cmd.iter     = (r_state == S_ITER);
        o_cmd.store    = (r_state == S_STORE);
        o_cmd.outer    = r_outer;
        o_cmd.load_out = (r_state == S_FINISH) && out_free;
        o_cmd.iter_idx = r_iter;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iter    <= '0;
            r_outer   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall)
                r_o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid)
                        r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_outer <= 1'b0;
                    r_state <= i_status.ack_work ? S_MULW : S_FINISH;
                end
                S_MULW:  r_state <= S_SETUP;
                S_SETUP: begin
                    r_iter  <= '0;
                    r_state <= i_status.special ? S_STORE : S_NORM;
                end
                S_NORM: begin
                    if (i_status.norm_done)
                        r_state <= S_ITER;
                end
                S_ITER: begin
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == ITER_LAST)
                        r_state <= S_STORE;
                end
                S_STORE: begin
                    if (!r_outer) begin
                        r_outer <= 1'b1;
                        r_state <= S_SETUP;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/rsd_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsd_dp
    import rsd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    input  wire logic [1:0]         i_cmd_code,
    input  wire logic signed [15:0] i_amount,
    output logic [14:0]             o_angle_front_left,
    output logic [14:0]             o_angle_front_right,
    output logic [14:0]             o_angle_rear_left,
    output logic [14:0]             o_angle_rear_right,
    output logic signed [14:0]      o_duty_front_left,
    output logic signed [14:0]      o_duty_front_right,
    output logic signed [14:0]      o_duty_rear_left,
    output logic signed [14:0]      o_duty_rear_right
);

    localparam logic signed [43:0] LIM40 = 44'sd1 <<< 40;
    localparam logic signed [43:0] LIM32 = 44'sd1 <<< 32;
    localparam logic signed [24:0] Z_MAX = 25'sd5898240;

    function automatic logic signed [43:0] shr_trunc(input logic signed [43:0] v,
                                                     input logic [ITER_W-1:0] s);
        logic signed [43:0] r;
        if (v < 0) r = -((-v) >>> s);
        else       r = v >>> s;
        return r;
    endfunction

    // latched word
    t_cmd               r_cmd;
    logic signed [15:0] r_raw;

    // wheel state
    logic [14:0]        r_ang [4];
    logic signed [14:0] r_duty [4];

    // Ackermann working registers
    logic [30:0]        r_num;
    logic [30:0]        r_w;
    logic signed [43:0] r_x, r_y;
    logic signed [24:0] r_z;
    logic               r_spec;
    logic [14:0]        r_spec_val;
    logic [13:0]        r_ang_in;

    // output register
    logic [14:0]        r_o_ang [4];
    logic signed [14:0] r_o_duty [4];

    // clamp and magnitude
    logic signed [15:0] a;
    logic [15:0]        raw_abs;
    logic [14:0]        mag;
    logic               a_pos, a_neg, drv_zero, steer_zero;

    always_comb begin
        if (r_raw > $signed({1'b0, 15'd16384}))       a = 16'sd16384;
        else if (r_raw < -$signed({1'b0, 15'd16384})) a = -16'sd16384;
        else                                          a = r_raw;
        raw_abs    = r_raw[15] ? 16'(-r_raw) : 16'(r_raw);
        mag        = a[15] ? 15'(-a) : 15'(a);
        a_pos      = !a[15] && (a != 16'sd0);
        a_neg      = a[15];
        drv_zero   = raw_abs < {1'b0, i_cfg.drive_db};
        steer_zero = mag < i_cfg.steer_db;
    end

    // duty and crab offset
    logic [14:0]        mag_t;
    logic [19:0]        duty_prod;
    logic [13:0]        duty_mag;
    logic signed [14:0] duty_s;
    logic [19:0]        crab_prod;
    logic [13:0]        crab_off;

    always_comb begin
        mag_t     = (r_cmd == CMD_TRACTION && drv_zero) ? 15'd0 : mag;
        duty_prod = 20'(mag_t) * 20'd25 + 20'd16;
        duty_mag  = duty_prod[18:5];
        duty_s    = a_neg ? -$signed({1'b0, duty_mag}) : $signed({1'b0, duty_mag});
        crab_prod = 20'(mag) * 20'd45 + 20'd32;
        crab_off  = crab_prod[19:6];
    end

    // shared multiplier
    logic [30:0] prod;
    assign prod = 31'((i_cmd.mul_w ? i_cfg.half_track : i_cfg.half_wbase) * mag);

    // denominator for the current pass
    logic signed [32:0] base_s, den;
    always_comb begin
        base_s = $signed({3'b0, i_cfg.min_radius, 14'd0});
        den    = i_cmd.outer ? base_s + $signed({2'b0, r_w}) : base_s - $signed({2'b0, r_w});
    end

    // status
    always_comb begin
        o_status.ack_work  = (r_cmd == CMD_ACKERMANN) && !steer_zero;
        o_status.special   = (r_num == 31'd0) || (den <= 33'sd0);
        o_status.norm_done = !((r_x < LIM40) && (r_y < LIM40));
    end

    // CORDIC step
    logic signed [43:0] xs, ys;
    logic signed [24:0] at;
    always_comb begin
        xs = shr_trunc(r_x, i_cmd.iter_idx);
        ys = shr_trunc(r_y, i_cmd.iter_idx);
        at = $signed({3'b0, atan_q16(i_cmd.iter_idx)});
    end

    // angle out of the accumulator
    logic signed [24:0] zc;
    logic [24:0]        zr;
    logic [13:0]        ang_now;
    always_comb begin
        if (r_z < 25'sd0)     zc = 25'sd0;
        else if (r_z > Z_MAX) zc = Z_MAX;
        else                  zc = r_z;
        zr      = 25'(zc) + 25'd256;
        ang_now = r_spec ? r_spec_val[13:0] : zr[22:9];
    end

    // main registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_ang[i]  <= CENTER_ANGLE;
                r_duty[i] <= '0;
            end
        end else begin
            if (i_cmd.latch) begin
                r_cmd <= t_cmd'(i_cmd_code);
                r_raw <= i_amount;
            end

            // traction, crab and pivot commands, or the first product for Ackermann
            if (i_cmd.exec) begin
                case (r_cmd)
                    CMD_TRACTION: begin
                        for (int i = 0; i < 4; i++)
                            r_duty[i] <= i_cfg.invert_mask[i] ? -duty_s : duty_s;
                    end
                    CMD_ACKERMANN: begin
                        if (steer_zero) begin
                            for (int i = 0; i < 4; i++) r_ang[i] <= CENTER_ANGLE;
                        end
                        r_num <= prod;
                    end
                    CMD_CRAB: begin
                        for (int i = 0; i < 4; i++)
                            r_ang[i] <= steer_zero ? CENTER_ANGLE :
                                        a_neg ? CENTER_ANGLE - 15'(crab_off)
                                              : CENTER_ANGLE + 15'(crab_off);
                    end
                    CMD_PIVOT: begin
                        r_ang[0] <= PIVOT_LOW;
                        r_ang[1] <= PIVOT_HIGH;
                        r_ang[2] <= PIVOT_HIGH;
                        r_ang[3] <= PIVOT_LOW;
                        r_duty[0] <= i_cfg.invert_mask[0] ? duty_s : -duty_s;
                        r_duty[1] <= i_cfg.invert_mask[1] ? -duty_s : duty_s;
                        r_duty[2] <= i_cfg.invert_mask[2] ? -duty_s : duty_s;
                        r_duty[3] <= i_cfg.invert_mask[3] ? duty_s : -duty_s;
                    end
                    default: ;
                endcase
            end

            if (i_cmd.mul_w)
                r_w <= prod;

            // load one arctangent pass
            if (i_cmd.setup) begin
                r_x        <= 44'(den);
                r_y        <= $signed({13'b0, r_num});
                r_z        <= '0;
                r_spec     <= o_status.special;
                r_spec_val <= (r_num == 31'd0) ? 15'd0 : CENTER_ANGLE;
            end

            // normalise operands towards 2^40
            if (i_cmd.norm) begin
                if (r_x < LIM32 && r_y < LIM32) begin
                    r_x <= r_x <<< 8;
                    r_y <= r_y <<< 8;
                end else begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end

            // one vectoring step
            if (i_cmd.iter) begin
                if (r_y > 44'sd0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end
            end

            // inner pass keeps its angle, outer pass commits all four
            if (i_cmd.store) begin
                if (!i_cmd.outer) begin
                    r_ang_in <= ang_now;
                end else if (a_pos) begin
                    r_ang[0] <= CENTER_ANGLE - 15'(ang_now);
                    r_ang[1] <= CENTER_ANGLE - 15'(r_ang_in);
                    r_ang[2] <= CENTER_ANGLE + 15'(ang_now);
                    r_ang[3] <= CENTER_ANGLE + 15'(r_ang_in);
                end else begin
                    r_ang[0] <= CENTER_ANGLE + 15'(r_ang_in);
                    r_ang[1] <= CENTER_ANGLE + 15'(ang_now);
                    r_ang[2] <= CENTER_ANGLE - 15'(r_ang_in);
                    r_ang[3] <= CENTER_ANGLE - 15'(ang_now);
                end
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            for (int i = 0; i < 4; i++) begin
                r_o_ang[i]  <= r_ang[i];
                r_o_duty[i] <= r_duty[i];
            end
        end
    end

    assign o_angle_front_left  = r_o_ang[0];
    assign o_angle_front_right = r_o_ang[1];
    assign o_angle_rear_left   = r_o_ang[2];
    assign o_angle_rear_right  = r_o_ang[3];
    assign o_duty_front_left   = r_o_duty[0];
    assign o_duty_front_right  = r_o_duty[1];
    assign o_duty_rear_left    = r_o_duty[2];
    assign o_duty_rear_right   = r_o_duty[3];

endmodule

`default_nettype wire

/* rtl/rover_steer_drive_setpoints.sv */
// Rover steering and drive setpoints. Each accepted word (cmd, amount in Q2.14)
// updates the four steering angles (1/128 degree, 11520 straight) and/or the
// four drive duties (1/128 percent) and returns one word with all eight values.
// Traction, crab, pivot and Ackermann inside the steering deadband are done
// in the execute state and loaded into the output register in the finish state.
// Otherwise Ackermann takes two CORDIC arctangent passes on one shared
// shift-add unit: per pass a load, normalisation of the operands (longer for
// small operands), 16 vectoring steps and a store; a degenerate pass (zero
// numerator or non-positive denominator) goes straight from load to store.
// The next word is taken once the previous one has been computed, while its
// result may still wait at the output. The user must write registers over the
// APB port only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module rover_steer_drive_setpoints
    import rsd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_cmd,
    input  wire logic signed [15:0] i_amount,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [14:0]             o_angle_front_left,
    output logic [14:0]             o_angle_front_right,
    output logic [14:0]             o_angle_rear_left,
    output logic [14:0]             o_angle_rear_right,
    output logic signed [14:0]      o_duty_front_left,
    output logic signed [14:0]      o_duty_front_right,
    output logic signed [14:0]      o_duty_rear_left,
    output logic signed [14:0]      o_duty_rear_right
);

    t_cfg       r_cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_radius  <= 16'd500;
            r_cfg.half_wbase  <= 16'd150;
            r_cfg.half_track  <= 16'd120;
            r_cfg.steer_db    <= 15'd819;
            r_cfg.drive_db    <= 15'd819;
            r_cfg.invert_mask <= 4'd0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_MIN_RADIUS:  r_cfg.min_radius  <= pwdata[15:0];
                REG_HALF_WBASE:  r_cfg.half_wbase  <= pwdata[15:0];
                REG_HALF_TRACK:  r_cfg.half_track  <= pwdata[15:0];
                REG_STEER_DB:    r_cfg.steer_db    <= pwdata[14:0];
                REG_DRIVE_DB:    r_cfg.drive_db    <= pwdata[14:0];
                REG_INVERT_MASK: r_cfg.invert_mask <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_MIN_RADIUS:  prdata = {16'd0, r_cfg.min_radius};
            REG_HALF_WBASE:  prdata = {16'd0, r_cfg.half_wbase};
            REG_HALF_TRACK:  prdata = {16'd0, r_cfg.half_track};
            REG_STEER_DB:    prdata = {17'd0, r_cfg.steer_db};
            REG_DRIVE_DB:    prdata = {17'd0, r_cfg.drive_db};
            REG_INVERT_MASK: prdata = {28'd0, r_cfg.invert_mask};
            default:         prdata = 32'd0;
        endcase
    end

    rsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    rsd_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_cmd               (dp_cmd),
        .o_status            (dp_status),
        .i_cmd_code          (i_cmd),
        .i_amount            (i_amount),
        .o_angle_front_left  (o_angle_front_left),
        .o_angle_front_right (o_angle_front_right),
        .o_angle_rear_left   (o_angle_rear_left),
        .o_angle_rear_right  (o_angle_rear_right),
        .o_duty_front_left   (o_duty_front_left),
        .o_duty_front_right  (o_duty_front_right),
        .o_duty_rear_left    (o_duty_rear_left),
        .o_duty_rear_right   (o_duty_rear_right)
    );

    // a taken word makes the input side busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken without going busy");

    // steering angles stay within 0 to 180 degrees
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle_front_left <= 15'd23040 && o_angle_front_right <= 15'd23040
                  && o_angle_rear_left <= 15'd23040 && o_angle_rear_right <= 15'd23040))
        else $error("steering angle out of range");

    // front-left and rear-right duties stay within full scale
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty_front_left >= -15'sd12800 && o_duty_front_left <= 15'sd12800
                  && o_duty_rear_right >= -15'sd12800 && o_duty_rear_right <= 15'sd12800))
        else $error("drive duty out of range");

endmodule

`default_nettype wire
